>>> rtl/zdt_pkg.sv
`timescale 1ns / 1ps

package zdt_pkg;

    localparam int ZONE_COUNT    = 16;
    localparam int COUNTER_WIDTH = 32;
    localparam int COORD_WIDTH   = 12;
    localparam int IDX_W         = 4;
    localparam int KIND_W        = 2;
    localparam int MASK_W        = 16;
    localparam int CALC_W        = COORD_WIDTH + 1;
    localparam int APB_DW        = 32;
    localparam int PADDR_W       = 3;

    localparam logic signed [COORD_WIDTH-1:0] X_OFFSET_RESET = COORD_WIDTH'(200);

    // Register index, taken from the word address bits of paddr.
    localparam logic [0:0] REG_X_OFFSET = 1'b0;

    localparam logic [KIND_W-1:0] KIND_NEUTRAL = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_TIMED   = KIND_W'(1);

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_SAMPLE = 3'd1,
        OP_TICK   = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_READ   = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]                    op;
        logic [IDX_W-1:0]              zone_index;
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
        logic signed [COORD_WIDTH-1:0] zone_left;
        logic signed [COORD_WIDTH-1:0] zone_top;
        logic signed [COORD_WIDTH-1:0] zone_width;
        logic signed [COORD_WIDTH-1:0] zone_height;
        logic [KIND_W-1:0]             zone_kind;
        logic                          zone_enable;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0]        occupied_mask;
        logic                     neutral_hit;
        logic [COUNTER_WIDTH-1:0] counter_value;
    } t_out_item;

    // Command as broadcast to the zone cells, with bounds already widened.
    typedef struct packed {
        logic [2:0]               op;
        logic [IDX_W-1:0]         idx;
        logic signed [CALC_W-1:0] px;
        logic signed [CALC_W-1:0] py;
        logic signed [CALC_W-1:0] left;
        logic signed [CALC_W-1:0] right;
        logic signed [CALC_W-1:0] top;
        logic signed [CALC_W-1:0] bottom;
        logic [KIND_W-1:0]        kind;
        logic                     en;
    } t_cmd;

endpackage

>>> rtl/zdt_cell.sv
`timescale 1ns / 1ps

module zdt_cell (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [zdt_pkg::IDX_W-1:0]           i_zone_id,
    input  logic                                i_cmd_valid,
    input  zdt_pkg::t_cmd                       i_cmd,
    input  logic                                i_hit,
    output logic                                o_hit,
    input  logic                                i_hit_all,
    input  logic [zdt_pkg::COUNTER_WIDTH-1:0]   i_rd,
    output logic [zdt_pkg::COUNTER_WIDTH-1:0]   o_rd,
    output logic                                o_occ_next
);
    import zdt_pkg::*;

    logic                     r_valid, n_valid;
    logic [KIND_W-1:0]        r_kind, n_kind;
    logic signed [CALC_W-1:0] r_left, n_left;
    logic signed [CALC_W-1:0] r_right, n_right;
    logic signed [CALC_W-1:0] r_top, n_top;
    logic signed [CALC_W-1:0] r_bottom, n_bottom;
    logic                     r_occ, n_occ;
    logic [COUNTER_WIDTH-1:0] r_cnt, n_cnt;
    logic                     w_sel;
    logic                     w_inside;
    logic                     w_neutral;

    // Half-open containment; no point matches if right <= left or bottom <= top.
    assign w_inside = (i_cmd.px >= r_left) && (i_cmd.px < r_right) &&
                      (i_cmd.py >= r_top)  && (i_cmd.py < r_bottom);
    assign w_neutral = r_valid && (r_kind == KIND_NEUTRAL) && w_inside;
    assign w_sel     = (i_cmd.idx == i_zone_id);

    assign o_hit = i_hit | (i_cmd_valid && (t_op'(i_cmd.op) == OP_SAMPLE) && w_neutral);
    assign o_rd  = i_rd | ((i_cmd_valid && (t_op'(i_cmd.op) == OP_READ) && w_sel) ?
                           r_cnt : '0);
    assign o_occ_next = n_occ;

    always_comb begin
        n_valid  = r_valid;
        n_kind   = r_kind;
        n_left   = r_left;
        n_right  = r_right;
        n_top    = r_top;
        n_bottom = r_bottom;
        n_occ    = r_occ;
        n_cnt    = r_cnt;
        if (i_cmd_valid) begin
            unique case (t_op'(i_cmd.op))
                OP_LOAD: begin
                    if (w_sel) begin
                        n_valid  = i_cmd.en;
                        n_kind   = i_cmd.kind;
                        n_left   = i_cmd.left;
                        n_right  = i_cmd.right;
                        n_top    = i_cmd.top;
                        n_bottom = i_cmd.bottom;
                        n_occ    = 1'b0;
                        n_cnt    = '0;
                    end
                end
                OP_SAMPLE: begin
                    if (i_hit_all) begin
                        n_occ = 1'b0;
                    end else if (r_valid && (r_kind == KIND_TIMED)) begin
                        n_occ = w_inside;
                    end
                end
                OP_TICK: begin
                    if (r_occ && (r_cnt != '1)) begin
                        n_cnt = r_cnt + COUNTER_WIDTH'(1);
                    end
                end
                OP_CLEAR: begin
                    if (w_sel) begin
                        n_cnt = '0;
                    end
                end
                OP_READ: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_occ   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_left   <= n_left;
        r_right  <= n_right;
        r_top    <= n_top;
        r_bottom <= n_bottom;
    end

endmodule

>>> rtl/zone_dwell_timer.sv
`timescale 1ns / 1ps

// Channel   Handshake                           Payload
// ------    ---------------------------------   ---------------------------------
// input     start high while busy low           i_item   (zdt_pkg::t_in_item)
// result    o_strobe high for one cycle         o_result (zdt_pkg::t_out_item)
// config    APB write: psel, penable, pwrite    pwdata[11:0] -> x_offset, paddr 0
//
// At the accepting edge the beat, with its sample shifted and its zone edges
// widened, goes into the command register. The zone cells act on it at the next
// edge, which also loads the result register, so the result is on the ports in
// the cycle after that edge.
// A new beat is taken in every cycle; busy stays low. Reset is synchronous and
// active low; it clears valid bits, occupied flags and counters at once.
// The receiver cannot stall: o_strobe marks each result for exactly one cycle.

module zone_dwell_timer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  zdt_pkg::t_in_item             i_item,
    output logic                          o_strobe,
    output zdt_pkg::t_out_item            o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [zdt_pkg::PADDR_W-1:0]   paddr,
    input  logic [zdt_pkg::APB_DW-1:0]    pwdata,
    output logic [zdt_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import zdt_pkg::*;

    logic signed [COORD_WIDTH-1:0] r_x_offset;
    logic                          r_cmd_valid;
    t_cmd                          r_cmd, n_cmd;
    logic                          r_strobe;
    t_out_item                     r_result, n_result;
    logic                          w_accept;
    logic                          w_cfg_write;

    logic                     w_hit_chain [ZONE_COUNT+1];
    logic [COUNTER_WIDTH-1:0] w_rd_chain  [ZONE_COUNT+1];
    logic [ZONE_COUNT-1:0]    w_occ_next;

    // Every beat completes in a fixed pipeline without back-pressure.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Configuration port: a single register, readable, writes complete at once.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready &&
                         (paddr[PADDR_W-1 -: 1] == REG_X_OFFSET);
    assign prdata      = (paddr[PADDR_W-1 -: 1] == REG_X_OFFSET) ?
                         APB_DW'(r_x_offset) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_offset <= X_OFFSET_RESET;
        end else if (w_cfg_write) begin
            r_x_offset <= pwdata[COORD_WIDTH-1:0];
        end
    end

    // The sample is shifted and the zone's far edges are formed here, one bit
    // wider than the coordinates so no sum can wrap.
    always_comb begin
        n_cmd.op     = i_item.op;
        n_cmd.idx    = i_item.zone_index;
        n_cmd.px     = CALC_W'(i_item.point_x) + CALC_W'(r_x_offset);
        n_cmd.py     = CALC_W'(i_item.point_y);
        n_cmd.left   = CALC_W'(i_item.zone_left);
        n_cmd.right  = CALC_W'(i_item.zone_left) + CALC_W'(i_item.zone_width);
        n_cmd.top    = CALC_W'(i_item.zone_top);
        n_cmd.bottom = CALC_W'(i_item.zone_top) + CALC_W'(i_item.zone_height);
        n_cmd.kind   = i_item.zone_kind;
        n_cmd.en     = i_item.zone_enable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
        end else begin
            r_cmd_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= n_cmd;
        end
    end

    // The row of zone cells. The neutral-hit flag and the read bus ripple from
    // cell to cell; the final hit is fed back to every cell so that a hit in
    // any neutral zone clears all occupied flags in the same step.
    assign w_hit_chain[0] = 1'b0;
    assign w_rd_chain[0]  = '0;

    for (genvar g = 0; g < ZONE_COUNT; g++) begin : g_cell
        zdt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_zone_id   (IDX_W'(g)),
            .i_cmd_valid (r_cmd_valid),
            .i_cmd       (r_cmd),
            .i_hit       (w_hit_chain[g]),
            .o_hit       (w_hit_chain[g+1]),
            .i_hit_all   (w_hit_chain[ZONE_COUNT]),
            .i_rd        (w_rd_chain[g]),
            .o_rd        (w_rd_chain[g+1]),
            .o_occ_next  (w_occ_next[g])
        );
    end

    // The mask shows the flags as they stand after the step; the read bus is
    // zero unless a read op selected a cell.
    always_comb begin
        n_result.occupied_mask = MASK_W'(w_occ_next);
        n_result.neutral_hit   = w_hit_chain[ZONE_COUNT];
        n_result.counter_value = w_rd_chain[ZONE_COUNT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmd_valid) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

>>> verif/zone_dwell_timer_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the zone dwell timer. Each accepted command beat is
// run through a software copy of the zone table, and the result that comes back
// is compared field by field with the oldest expected result.

module zone_dwell_timer_tb;

    import zdt_pkg::*;

    // The scoreboard keeps its own copy of the zone table, the occupied flags,
    // the dwell counters and the x offset register. It also queues up the
    // expected results, oldest first.
    class zone_scoreboard;
        int                       x_off = 200;
        int                       zl[ZONE_COUNT];
        int                       zt[ZONE_COUNT];
        int                       zw[ZONE_COUNT];
        int                       zh[ZONE_COUNT];
        logic [KIND_W-1:0]        zk[ZONE_COUNT];
        bit                       zv[ZONE_COUNT];
        bit                       occ[ZONE_COUNT];
        logic [COUNTER_WIDTH-1:0] dwell[ZONE_COUNT];
        t_out_item                expected_q[$];
        int                       errors = 0;

        function new();
            foreach (zl[i]) begin
                zl[i] = 0; zt[i] = 0; zw[i] = 0; zh[i] = 0;
                zk[i] = '0; zv[i] = 0; occ[i] = 0; dwell[i] = '0;
            end
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // The bounds are half-open, so a zone with no width or no height is empty.
        function bit contains(int z, int px, int py);
            return px >= zl[z] && px < zl[z] + zw[z] && py >= zt[z] && py < zt[z] + zh[z];
        endfunction

        task note_beat(t_in_item it);
            t_out_item res;
            int        z;
            int        px;
            int        py;
            bit        hit;
            res = '0;
            hit = 0;
            z   = int'(it.zone_index);
            case (it.op)
                OP_LOAD: begin
                    // A disabled load wipes the whole entry, geometry and kind too.
                    zl[z]    = it.zone_enable ? int'($signed(it.zone_left))   : 0;
                    zt[z]    = it.zone_enable ? int'($signed(it.zone_top))    : 0;
                    zw[z]    = it.zone_enable ? int'($signed(it.zone_width))  : 0;
                    zh[z]    = it.zone_enable ? int'($signed(it.zone_height)) : 0;
                    zk[z]    = it.zone_enable ? it.zone_kind : '0;
                    zv[z]    = it.zone_enable;
                    occ[z]   = 0;
                    dwell[z] = '0;
                end
                OP_SAMPLE: begin
                    px = int'($signed(it.point_x)) + x_off;
                    py = int'($signed(it.point_y));
                    for (int i = 0; i < ZONE_COUNT; i++)
                        if (zv[i] && zk[i] == KIND_NEUTRAL && contains(i, px, py))
                            hit = 1;
                    for (int i = 0; i < ZONE_COUNT; i++) begin
                        if (hit)
                            occ[i] = 0;
                        else if (zv[i] && zk[i] == KIND_TIMED)
                            occ[i] = contains(i, px, py);
                    end
                end
                OP_TICK: begin
                    for (int i = 0; i < ZONE_COUNT; i++)
                        if (occ[i] && dwell[i] != '1)
                            dwell[i] = dwell[i] + 1'b1;
                end
                OP_CLEAR: dwell[z] = '0;
                OP_READ:  res.counter_value = dwell[z];
                default: ;
            endcase
            for (int i = 0; i < ZONE_COUNT; i++)
                res.occupied_mask[i] = occ[i];
            res.neutral_hit = hit;
            expected_q.push_back(res);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (expected_q.size() == 0) begin
                report($sformatf("result with nothing expected: %p", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.occupied_mask !== want.occupied_mask)
                report($sformatf("occupied_mask %h, expected %h",
                                 got.occupied_mask, want.occupied_mask));
            if (got.neutral_hit !== want.neutral_hit)
                report($sformatf("neutral_hit %b, expected %b",
                                 got.neutral_hit, want.neutral_hit));
            if (got.counter_value !== want.counter_value)
                report($sformatf("counter_value %0d, expected %0d",
                                 got.counter_value, want.counter_value));
        endtask
    endclass

    // Every input of the block starts at a known value, and reset starts out low.
    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_in_item  i_item  = '0;
    logic      o_strobe;
    t_out_item o_result;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [APB_DW-1:0]   pwdata  = '0;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    zone_scoreboard sb = new();

    always #1 i_clk = ~i_clk;

    zone_dwell_timer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // The monitor samples at the rising edge, so it sees the values that the
    // block itself sees there. The input beat is noted before any result of the
    // same edge is checked, which keeps the order right even for a purely
    // combinational block.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_beat(i_item);
            if (o_strobe)
                sb.check_result(o_result);
        end
    end

    // Drives one command beat and returns after the edge that accepts it. The
    // start line stays high, so back-to-back beats need no second assignment.
    task automatic send_beat(input t_in_item it);
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
    endtask

    // Before each beat the sender may go quiet, deciding cycle by cycle with the
    // given odds in percent, so that gaps of every length fall on both pipeline
    // stages of the block.
    task automatic maybe_idle(input int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Waits until every expected result has come back, plus a few cycles to
    // cover the two-stage pipeline, so that a register write sees an idle block.
    task automatic settle();
        start <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of the x offset: a setup cycle, then an access cycle that ends
    // at the edge where pready is seen high. The predictor follows at once,
    // since the block holds no beat in flight here.
    task automatic write_x_offset(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * REG_X_OFFSET);
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.x_off = value;
    endtask

    function automatic t_in_item load_cmd(input int idx, input int left, input int top,
                                          input int w, input int h, input int kind,
                                          input bit en);
        t_in_item it;
        it             = '0;
        it.op          = OP_LOAD;
        it.zone_index  = IDX_W'(idx);
        it.zone_left   = COORD_WIDTH'(left);
        it.zone_top    = COORD_WIDTH'(top);
        it.zone_width  = COORD_WIDTH'(w);
        it.zone_height = COORD_WIDTH'(h);
        it.zone_kind   = KIND_W'(kind);
        it.zone_enable = en;
        return it;
    endfunction

    function automatic t_in_item sample_cmd(input int x, input int y);
        t_in_item it;
        it         = '0;
        it.op      = OP_SAMPLE;
        it.point_x = COORD_WIDTH'(x);
        it.point_y = COORD_WIDTH'(y);
        return it;
    endfunction

    function automatic t_in_item zone_cmd(input t_op op, input int idx);
        t_in_item it;
        it            = '0;
        it.op         = op;
        it.zone_index = IDX_W'(idx);
        return it;
    endfunction

    function automatic int random_coord();
        return int'($urandom_range(4095)) - 2048;
    endfunction

    // Zone sizes are mostly modest so that aimed samples land often, with a
    // share of empty, negative and extreme sizes mixed in.
    function automatic int random_size();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(1, 600);
        if (r < 90)
            return random_coord();
        case ($urandom_range(3))
            0:       return 0;
            1:       return -1;
            2:       return 2047;
            default: return -2048;
        endcase
    endfunction

    // Random command beat. All fields start out fully random, so the fields
    // that an op ignores still toggle every bit, and the fields that matter are
    // then shaped. Most samples are aimed inside a zone that the scoreboard
    // knows, or just across one of its edges; the rest land anywhere.
    function automatic t_in_item random_beat();
        t_in_item                   it;
        logic [$bits(t_in_item)-1:0] raw;
        int                         r;
        int                         z;
        int                         tx;
        int                         ty;
        raw = $bits(t_in_item)'({$urandom(), $urandom(), $urandom()});
        it  = t_in_item'(raw);
        r   = $urandom_range(99);
        if (r < 15) begin
            it.op          = OP_LOAD;
            it.zone_enable = ($urandom_range(9) != 0);
            r              = $urandom_range(99);
            it.zone_kind   = (r < 15) ? KIND_NEUTRAL :
                             (r < 80) ? KIND_TIMED : KIND_W'($urandom_range(2, 3));
            if ($urandom_range(1)) begin
                it.zone_left = COORD_WIDTH'($urandom_range(1200) - 600);
                it.zone_top  = COORD_WIDTH'($urandom_range(1200) - 600);
            end
            it.zone_width  = COORD_WIDTH'(random_size());
            it.zone_height = COORD_WIDTH'(random_size());
        end else if (r < 55) begin
            it.op = OP_SAMPLE;
            z     = $urandom_range(ZONE_COUNT - 1);
            if ($urandom_range(9) < 7 && sb.zv[z] && sb.zw[z] > 0 && sb.zh[z] > 0) begin
                tx = sb.zl[z] + int'($urandom_range(sb.zw[z] - 1));
                ty = sb.zt[z] + int'($urandom_range(sb.zh[z] - 1));
                case ($urandom_range(7))
                    0: tx = sb.zl[z] - 1;
                    1: tx = sb.zl[z] + sb.zw[z];
                    2: ty = sb.zt[z] - 1;
                    3: ty = sb.zt[z] + sb.zh[z];
                    default: ;
                endcase
                tx = tx - sb.x_off;
                if (tx >= -2048 && tx <= 2047 && ty >= -2048 && ty <= 2047) begin
                    it.point_x = COORD_WIDTH'(tx);
                    it.point_y = COORD_WIDTH'(ty);
                end
            end
        end else if (r < 80) begin
            it.op = OP_TICK;
        end else if (r < 87) begin
            it.op = OP_CLEAR;
        end else begin
            it.op = OP_READ;
        end
        return it;
    endfunction

    initial begin
        int idle_pct[4];
        int offsets[4];
        idle_pct = '{18, 60, 0, 0};
        offsets  = '{-2048, 2047, 0, 0};
        offsets[3] = random_coord();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats, run with the x offset still at its reset value of 200.
        // A read and a sample on an empty table give all zeros.
        send_beat(zone_cmd(OP_READ, 0));
        send_beat(sample_cmd(0, 0));
        // A timed zone in the far lower corner and one at the far upper corner,
        // whose right and bottom bounds only fit at full precision.
        send_beat(load_cmd(0, -2048, -2048, 2047, 2047, KIND_TIMED, 1'b1));
        send_beat(load_cmd(15, 2047, 2047, 2047, 2047, KIND_TIMED, 1'b1));
        // A neutral zone near the origin, overlapped by two inert zones.
        send_beat(load_cmd(1, 0, 0, 100, 100, KIND_NEUTRAL, 1'b1));
        send_beat(load_cmd(2, 0, 0, 100, 100, 2, 1'b1));
        send_beat(load_cmd(3, -50, -50, 200, 200, 3, 1'b1));
        // Timed zones with zero, negative and most negative sizes stay empty.
        send_beat(load_cmd(4, -200, 0, 0, 50, KIND_TIMED, 1'b1));
        send_beat(load_cmd(5, -200, 0, 50, -1, KIND_TIMED, 1'b1));
        send_beat(load_cmd(6, -200, 0, -2048, 2047, KIND_TIMED, 1'b1));
        // Samples at both ends of the coordinate range.
        send_beat(sample_cmd(-2048, -2048));
        send_beat(zone_cmd(OP_TICK, 0));
        send_beat(zone_cmd(OP_TICK, 0));
        send_beat(zone_cmd(OP_READ, 0));
        send_beat(sample_cmd(1847, 2047));
        send_beat(sample_cmd(2047, -2048));
        // Exactly on the exclusive right edge of zone 0, then inside it again.
        send_beat(sample_cmd(-201, -2048));
        send_beat(sample_cmd(-2048, -2049 + 1));
        // Clearing the counter leaves the occupied flag set, so it counts on.
        send_beat(zone_cmd(OP_CLEAR, 0));
        send_beat(zone_cmd(OP_TICK, 0));
        send_beat(zone_cmd(OP_READ, 0));
        // Inside the neutral zone every flag drops, inert zones included.
        send_beat(sample_cmd(-150, 50));
        // A disabled load leaves an invalid entry that must never count as neutral.
        send_beat(load_cmd(0, -2048, -2048, 2047, 2047, KIND_TIMED, 1'b0));
        send_beat(zone_cmd(OP_READ, 0));
        send_beat(sample_cmd(-200, 0));
        settle();

        // Random phases, each under its own x offset: the sender first idles
        // now and then, then often, then not at all.
        for (int p = 0; p < 4; p++) begin
            write_x_offset(offsets[p]);
            for (int n = 0; n < 125; n++) begin
                maybe_idle(idle_pct[p]);
                send_beat(random_beat());
            end
            settle();
        end

        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        if (sb.errors == 0)
            $display("zone_dwell_timer_tb: PASS");
        else
            $display("zone_dwell_timer_tb: FAIL");
        $finish;
    end

    // The timeout leaves a correct run ample room.
    initial begin
        #200000;
        $display("zone_dwell_timer_tb: FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/zdt_pkg.sv
rtl/zdt_cell.sv
rtl/zone_dwell_timer.sv
verif/zone_dwell_timer_tb.sv
